// ===== rtl/tfn_pkg.sv =====
// Shared constants and codes for the triangle face normal unit.
`timescale 1ns / 1ps
package tfn_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int COORD_WIDTH_DEF = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FACE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // Unit length in signed Q2.14.
  localparam int NORM_FRAC = 14;

endpackage

// ===== rtl/triangle_face_normal_unit_core.sv =====
// Top level of the triangle face normal unit: vertex table and normal sequencer.
`timescale 1ns / 1ps
// Vertex write transfers (op 0) store a position into the vertex table; a write to a slot
// at or beyond TABLE_DEPTH is dropped. A face transfer (op 1) reads its three corners one
// after another through the single read port of the table memory, forms the differences,
// forms the exact cross product with one shared multiplier, takes magnitudes and normalizes
// them to 31 bits. It then forms the sum of squares, takes the bit-serial square root and
// performs the three bit-serial divisions. Its results are then loaded at one result per
// cycle when the receiver does not stall. A degenerate face goes from the normalization
// straight to its results. A face with a bad or unwritten corner gives one result. Only
// one face is in flight at a time, and the input stalls while it is processed. The last
// result may still wait in the output register while the next item is taken. After reset
// the written marks are cleared by a pass over all TABLE_DEPTH slots, during which the
// input channel is stalled.
module triangle_face_normal_unit_core #(
  parameter int TABLE_DEPTH = tfn_pkg::TABLE_DEPTH_DEF,
  parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [15:0]        in_write_index,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [15:0]        in_corner_a,
  input  logic [15:0]        in_corner_b,
  input  logic [15:0]        in_corner_c,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic [1:0]         out_status,
  output logic               out_last_corner
);
  import tfn_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;           // corner difference
  localparam int PW = 2 * DW;           // product of two differences
  localparam int XW = PW + 1;           // cross product component
  localparam int MW = 2 * CW + 1;       // cross product magnitude
  localparam int HW = (MW > 40) ? MW : 40;
  localparam int NW = 31 + NORM_FRAC + 1; // rounded numerator

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_RW   = 4'd3;
  localparam logic [3:0] S_DIF  = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_ABS  = 4'd6;
  localparam logic [3:0] S_NRM  = 4'd7;
  localparam logic [3:0] S_SQ   = 4'd8;
  localparam logic [3:0] S_ROOT = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_EMIT = 4'd11;

  logic [3:0] state_r, state_nxt;

  // Table memories. Writes happen only while idle, or in the clearing pass for marks.
  logic [3*CW-1:0] vs_mem [TABLE_DEPTH];
  logic            mk_mem [TABLE_DEPTH];
  logic [3*CW-1:0] vs_q;
  logic            mk_q;

  logic [AW-1:0]   clr_r;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            wr_en;
  logic            in_take;

  logic [15:0]     corner_r [3];
  logic [1:0]      k_r;
  logic [5:0]      cnt_r;
  logic [4:0]      dcnt_r;
  logic            err_r;
  logic            degen_r;

  logic signed [CW-1:0] px_r [3];
  logic signed [CW-1:0] py_r [3];
  logic signed [CW-1:0] pz_r [3];
  logic signed [DW-1:0] dif_r [6];   // ax ay az bx by bz
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] acc_r;
  logic signed [XW-1:0] cr_r [3];
  logic [HW-1:0]        mag_r [3];
  logic                 neg_r [3];
  logic [61:0]          sq_r;
  logic [63:0]          sum_r;
  logic [63:0]          rv_r;
  logic [63:0]          rr_r;
  logic [63:0]          rbit_r;
  logic [31:0]          len_r;
  logic [33:0]          rem_r;
  logic [15:0]          sh_r;
  logic [15:0]          q_r;
  logic [15:0]          nrm_r [3];

  logic                 out_load;
  logic [1:0]           cur_corner_k;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  assign wr_addr = in_write_index[AW-1:0];
  assign wr_en   = in_take && (in_op == OP_WRITE) && (17'(in_write_index) < 17'(TABLE_DEPTH));
  assign rd_addr = corner_r[k_r][AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vs_mem[wr_addr] <= {in_pos_z[CW-1:0], in_pos_y[CW-1:0], in_pos_x[CW-1:0]};
    end
    vs_q <= vs_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLR) begin
      mk_mem[clr_r] <= 1'b0;
    end else if (wr_en) begin
      mk_mem[wr_addr] <= 1'b1;
    end
    mk_q <= mk_mem[rd_addr];
  end

  // Shared cross product multiplier: operand pair chosen by the step count.
  logic signed [DW-1:0] mul_a, mul_b;
  always_comb begin
    unique case (cnt_r[2:0])
      3'd0:    begin mul_a = dif_r[1]; mul_b = dif_r[5]; end
      3'd1:    begin mul_a = dif_r[2]; mul_b = dif_r[4]; end
      3'd2:    begin mul_a = dif_r[2]; mul_b = dif_r[3]; end
      3'd3:    begin mul_a = dif_r[0]; mul_b = dif_r[5]; end
      3'd4:    begin mul_a = dif_r[0]; mul_b = dif_r[4]; end
      default: begin mul_a = dif_r[1]; mul_b = dif_r[3]; end
    endcase
  end

  // Normalizing shift decisions on the OR of the three magnitudes.
  logic [HW-1:0] or_mag;
  assign or_mag = mag_r[0] | mag_r[1] | mag_r[2];

  // Square root step.
  logic [63:0] root_t;
  logic        root_ge;
  assign root_t  = rr_r + rbit_r;
  assign root_ge = (rv_r >= root_t);

  // Division step.
  logic [NW-1:0] div_num;
  logic [1:0]    dj;
  logic [33:0]   div_t;
  logic          div_ge;
  assign dj      = k_r;
  assign div_num = NW'({mag_r[dj][30:0], {NORM_FRAC{1'b0}}}) + NW'(len_r >> 1);
  assign div_t   = {rem_r[32:0], sh_r[15]};
  assign div_ge  = (div_t >= 34'(len_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:  if (clr_r == AW'(TABLE_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_take && in_op == OP_FACE) state_nxt = S_RD;
      S_RD: begin
        if (17'(corner_r[k_r]) >= 17'(TABLE_DEPTH)) state_nxt = S_EMIT;
        else state_nxt = S_RW;
      end
      S_RW: begin
        if (!mk_q) state_nxt = S_EMIT;
        else if (k_r == 2'd2) state_nxt = S_DIF;
        else state_nxt = S_RD;
      end
      S_DIF:  state_nxt = S_MUL;
      S_MUL:  if (cnt_r == 6'd6) state_nxt = S_ABS;
      S_ABS:  state_nxt = S_NRM;
      S_NRM: begin
        if (or_mag == '0) state_nxt = S_EMIT;
        else if (or_mag[HW-1:31] == '0 && or_mag[30]) state_nxt = S_SQ;
      end
      S_SQ:   if (cnt_r == 6'd3) state_nxt = S_ROOT;
      S_ROOT: if (cnt_r == 6'd31) state_nxt = S_DIV;
      S_DIV:  if (dcnt_r == 5'd17 && k_r == 2'd2) state_nxt = S_EMIT;
      S_EMIT: if (out_load && (err_r || k_r == 2'd2)) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + AW'(1);
    end
  end

  // Datapath registers; each is set before it is used, so they need no reset.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        corner_r[0] <= in_corner_a;
        corner_r[1] <= in_corner_b;
        corner_r[2] <= in_corner_c;
        k_r         <= 2'd0;
        err_r       <= 1'b0;
        degen_r     <= 1'b0;
      end
      S_RD: if (17'(corner_r[k_r]) >= 17'(TABLE_DEPTH)) begin
        err_r <= 1'b1;
      end
      S_RW: begin
        if (!mk_q) begin
          err_r <= 1'b1;
        end else begin
          px_r[k_r] <= vs_q[CW-1:0];
          py_r[k_r] <= vs_q[2*CW-1:CW];
          pz_r[k_r] <= vs_q[3*CW-1:2*CW];
          if (k_r != 2'd2) k_r <= k_r + 2'd1;
        end
        cnt_r <= '0;
      end
      S_DIF: begin
        dif_r[0] <= DW'(px_r[0]) - DW'(px_r[1]);
        dif_r[1] <= DW'(py_r[0]) - DW'(py_r[1]);
        dif_r[2] <= DW'(pz_r[0]) - DW'(pz_r[1]);
        dif_r[3] <= DW'(px_r[0]) - DW'(px_r[2]);
        dif_r[4] <= DW'(py_r[0]) - DW'(py_r[2]);
        dif_r[5] <= DW'(pz_r[0]) - DW'(pz_r[2]);
      end
      S_MUL: begin
        prod_r <= mul_a * mul_b;
        if (cnt_r != 6'd0) begin
          if (cnt_r[0]) acc_r <= prod_r;
          else cr_r[cnt_r[2:1] - 2'd1] <= XW'(acc_r) - XW'(prod_r);
        end
        cnt_r <= cnt_r + 6'd1;
      end
      S_ABS: begin
        for (int j = 0; j < 3; j++) begin
          neg_r[j] <= cr_r[j][XW-1];
          mag_r[j] <= HW'(cr_r[j][XW-1] ? MW'(-cr_r[j]) : MW'(cr_r[j]));
        end
        cnt_r <= '0;
      end
      S_NRM: begin
        if (or_mag == '0) begin
          degen_r <= 1'b1;
        end else if (or_mag[HW-1:31] != '0) begin
          // Repeated truncating right shifts compose to one truncating shift.
          for (int j = 0; j < 3; j++) begin
            if (or_mag[HW-1:39] != '0) mag_r[j] <= mag_r[j] >> 8;
            else mag_r[j] <= mag_r[j] >> 1;
          end
        end else if (!or_mag[30]) begin
          for (int j = 0; j < 3; j++) begin
            if (or_mag[30:22] == '0) mag_r[j] <= mag_r[j] << 8;
            else mag_r[j] <= mag_r[j] << 1;
          end
        end
        k_r    <= 2'd0;
        cnt_r  <= '0;
        sum_r  <= '0;
      end
      S_SQ: begin
        if (cnt_r != 6'd3) sq_r <= mag_r[cnt_r[1:0]][30:0] * mag_r[cnt_r[1:0]][30:0];
        if (cnt_r != 6'd0) sum_r <= sum_r + 64'(sq_r);
        if (cnt_r == 6'd3) begin
          cnt_r  <= '0;
          rv_r   <= sum_r + 64'(sq_r);
          rr_r   <= '0;
          rbit_r <= 64'h4000_0000_0000_0000;
        end else begin
          cnt_r <= cnt_r + 6'd1;
        end
      end
      S_ROOT: begin
        if (root_ge) begin
          rv_r <= rv_r - root_t;
          rr_r <= (rr_r >> 1) + rbit_r;
        end else begin
          rr_r <= rr_r >> 1;
        end
        rbit_r <= rbit_r >> 2;
        cnt_r  <= cnt_r + 6'd1;
        dcnt_r <= '0;
        k_r    <= 2'd0;
        len_r  <= root_ge ? 32'((rr_r >> 1) + rbit_r) : 32'(rr_r >> 1);
      end
      S_DIV: begin
        if (dcnt_r == 5'd0) begin
          rem_r <= 34'(div_num[NW-1:16]);
          sh_r  <= div_num[15:0];
          dcnt_r <= dcnt_r + 5'd1;
        end else if (dcnt_r != 5'd17) begin
          rem_r <= div_ge ? (div_t - 34'(len_r)) : div_t;
          sh_r  <= sh_r << 1;
          q_r   <= {q_r[14:0], div_ge};
          dcnt_r <= dcnt_r + 5'd1;
        end else begin
          nrm_r[k_r] <= neg_r[k_r] ? -q_r : q_r;
          dcnt_r <= '0;
          k_r    <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        end
      end
      S_EMIT: if (out_load && !err_r && k_r != 2'd2) begin
        k_r <= k_r + 2'd1;
      end
      default: ;
    endcase
    if (state_r == S_RW && mk_q && k_r == 2'd2) k_r <= 2'd0;
  end

  // Output register: a result is loaded only when the previous one is gone.
  logic               out_valid_r;
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic signed [15:0] nx_r, ny_r, nz_r;
  logic [1:0]         ost_r;
  logic               olast_r;

  assign out_load     = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign cur_corner_k = k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (err_r) begin
        ox_r <= '0; oy_r <= '0; oz_r <= '0;
        nx_r <= '0; ny_r <= '0; nz_r <= '0;
        ost_r   <= ST_BAD;
        olast_r <= 1'b1;
      end else begin
        ox_r <= 32'(px_r[cur_corner_k]);
        oy_r <= 32'(py_r[cur_corner_k]);
        oz_r <= 32'(pz_r[cur_corner_k]);
        nx_r <= degen_r ? 16'sd0 : nrm_r[0];
        ny_r <= degen_r ? 16'sd0 : nrm_r[1];
        nz_r <= degen_r ? 16'sd0 : nrm_r[2];
        ost_r   <= degen_r ? ST_DEGEN : ST_OK;
        olast_r <= (cur_corner_k == 2'd2);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x           = ox_r;
  assign out_y           = oy_r;
  assign out_z           = oz_r;
  assign out_norm_x      = nx_r;
  assign out_norm_y      = ny_r;
  assign out_norm_z      = nz_r;
  assign out_status      = ost_r;
  assign out_last_corner = olast_r;

endmodule

// ===== rtl/tfn_chk.sv =====
// Port-level checker for the triangle face normal unit, bound to the top level.
`timescale 1ns / 1ps
module tfn_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_x,
  input logic signed [15:0] out_norm_x,
  input logic signed [15:0] out_norm_y,
  input logic signed [15:0] out_norm_z,
  input logic [1:0]         out_status,
  input logic               out_last_corner
);
  import tfn_pkg::*;

  // The mark clearing pass holds the input off right after reset.
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during mark clearing pass");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_status))
    else $error("stalled result changed");

  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BAD |-> out_last_corner && out_x == 32'sd0)
    else $error("bad index result malformed");

  a_norm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_norm_x == 16'sd0 && out_norm_y == 16'sd0 && out_norm_z == 16'sd0)
    else $error("nonzero normal on failed face");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |->
      out_norm_x <= 16'sd16384 && out_norm_x >= -16'sd16384 &&
      out_norm_y <= 16'sd16384 && out_norm_y >= -16'sd16384)
    else $error("normal component out of range");

endmodule

bind triangle_face_normal_unit_core tfn_chk u_tfn_chk (.*);

// ===== test/triangle_face_normal_unit_core_tb.sv =====
// Self-checking testbench for the triangle face normal unit: vertex writes, faces, normals.
`timescale 1ns / 1ps
module triangle_face_normal_unit_core_tb;
  import tfn_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;

  // One input transfer as the driver presents it.
  typedef struct packed {
    logic        op;
    logic [15:0] widx;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [15:0] ca;
    logic [15:0] cb;
    logic [15:0] cc;
  } item_t;

  // One result transfer as the block should produce it.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic [1:0]  status;
    logic        last;
  } corner_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = 1'b0;
  logic [15:0] in_write_index = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [15:0] in_corner_a = '0, in_corner_b = '0, in_corner_c = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic signed [15:0] out_norm_x, out_norm_y, out_norm_z;
  logic [1:0] out_status;
  logic out_last_corner;

  triangle_face_normal_unit_core dut (.*);

  always #6 clk = ~clk;

  item_t   pending_items[$];
  corner_t expected_corners[$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      faces_sent = 0;
  int      corners_seen = 0;
  bit      stimulus_done = 0;

  // The predictor's own copy of the vertex table.
  logic signed [31:0] vtx_x[DEPTH];
  logic signed [31:0] vtx_y[DEPTH];
  logic signed [31:0] vtx_z[DEPTH];
  bit                 vtx_written[DEPTH];

  task automatic queue_item(item_t it);
    pending_items = {pending_items, it};
  endtask

  // Rounded component m*16384/len, then given the sign of the cross component.
  function automatic logic [15:0] unit_component(logic [63:0] m, bit neg, logic [63:0] len);
    logic [63:0] q;
    q = (m * 64'd16384 + len / 2) / len;
    if (neg) q = -q;
    return q[15:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Applies one accepted item to the table and queues the corners it causes.
  task automatic predict_face(item_t it);
    logic [15:0] idx[3];
    logic signed [67:0] ax, ay, az, bx, by, bz;
    logic signed [67:0] cr[3];
    logic [67:0] mag[3];
    logic [63:0] sm[3];
    logic [63:0] len;
    logic [15:0] nrm[3];
    int bl, l;
    corner_t c;
    if (it.op == OP_WRITE) begin
      if (it.widx < DEPTH) begin
        vtx_x[it.widx] = it.px;
        vtx_y[it.widx] = it.py;
        vtx_z[it.widx] = it.pz;
        vtx_written[it.widx] = 1;
      end
      return;
    end
    idx[0] = it.ca;
    idx[1] = it.cb;
    idx[2] = it.cc;
    for (int k = 0; k < 3; k++) begin
      if (idx[k] >= DEPTH || !vtx_written[idx[k]]) begin
        c = '0;
        c.status = ST_BAD;
        c.last = 1'b1;
        expected_corners = {expected_corners, c};
        return;
      end
    end
    ax = 68'(vtx_x[idx[0]]) - 68'(vtx_x[idx[1]]);
    ay = 68'(vtx_y[idx[0]]) - 68'(vtx_y[idx[1]]);
    az = 68'(vtx_z[idx[0]]) - 68'(vtx_z[idx[1]]);
    bx = 68'(vtx_x[idx[0]]) - 68'(vtx_x[idx[2]]);
    by = 68'(vtx_y[idx[0]]) - 68'(vtx_y[idx[2]]);
    bz = 68'(vtx_z[idx[0]]) - 68'(vtx_z[idx[2]]);
    cr[0] = ay * bz - az * by;
    cr[1] = az * bx - ax * bz;
    cr[2] = ax * by - ay * bx;
    l = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = cr[k] < 0 ? -cr[k] : cr[k];
      bl = 0;
      for (int b = 0; b < 68; b++) if (mag[k][b]) bl = b + 1;
      if (bl > l) l = bl;
    end
    nrm = '{default: '0};
    if (l != 0) begin
      // The largest magnitude is brought to exactly 31 bits.
      for (int k = 0; k < 3; k++)
        sm[k] = l > 31 ? 64'(mag[k] >> (l - 31)) : 64'(mag[k] << (31 - l));
      len = int_sqrt(sm[0] * sm[0] + sm[1] * sm[1] + sm[2] * sm[2]);
      for (int k = 0; k < 3; k++) nrm[k] = unit_component(sm[k], cr[k] < 0, len);
    end
    for (int k = 0; k < 3; k++) begin
      c.x = vtx_x[idx[k]];
      c.y = vtx_y[idx[k]];
      c.z = vtx_z[idx[k]];
      c.nx = nrm[0];
      c.ny = nrm[1];
      c.nz = nrm[2];
      c.status = (l == 0) ? ST_DEGEN : ST_OK;
      c.last = (k == 2);
      expected_corners = {expected_corners, c};
    end
  endtask

  function automatic item_t vertex_write(int w, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    item_t it;
    it = '0;
    it.op = OP_WRITE;
    it.widx = 16'(w);
    it.px = x;
    it.py = y;
    it.pz = z;
    it.ca = 16'($urandom);
    it.cb = 16'($urandom);
    it.cc = 16'($urandom);
    return it;
  endfunction

  function automatic item_t face(int a, int b, int c);
    item_t it;
    it = '0;
    it.op = OP_FACE;
    it.widx = 16'($urandom);
    it.px = $urandom;
    it.py = $urandom;
    it.pz = $urandom;
    it.ca = 16'(a);
    it.cb = 16'(b);
    it.cc = 16'(c);
    return it;
  endfunction

  // Random coordinate: mostly small, sometimes full range, sometimes an extreme.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< $urandom_range(0, 16);
    endcase
  endfunction

  // Input stall as seen at the last rising edge.
  logic in_stall_at_edge = 1'b1;

  // Driver: the gap drawn for an item is counted down before the next one is offered.
  int gap_left = 0;
  always @(negedge clk) begin
    int gap_now;
    if (rst_n) begin
      gap_now = gap_left;
      if (in_valid && !in_stall_at_edge) begin
        // Transfer completed at the last rising edge.
        if (pending_items.size() != 0) void'(pending_items.pop_front());
        gap_now = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      end
      if (!in_valid || !in_stall_at_edge) begin
        if (gap_now > 0 || pending_items.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_now > 0) gap_now = gap_now - 1;
        end else begin
          in_valid <= 1'b1;
          {in_op, in_write_index, in_pos_x, in_pos_y, in_pos_z,
           in_corner_a, in_corner_b, in_corner_c} <= pending_items[0];
        end
      end
      gap_left <= gap_now;
    end
  end

  // Accepted input transfers are predicted at the rising edge.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_stall_at_edge <= in_stall;
    if (rst_n && in_valid && !in_stall) begin
      predict_face(pending_items[0]);
      if (in_op == OP_FACE) faces_sent <= faces_sent + 1;
    end
  end

  // Monitor: checks each result transfer against the oldest expected corner.
  bit out_took = 1'b0;
  always @(posedge clk) begin
    corner_t exp_c, got;
    out_took <= 1'b0;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_x, out_y, out_z, out_norm_x, out_norm_y, out_norm_z,
              out_status, out_last_corner};
      corners_seen <= corners_seen + 1;
      if (expected_corners.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count <= error_count + 1;
      end else begin
        exp_c = expected_corners.pop_front();
        if (got !== exp_c) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h n=%h,%h,%h st=%0d last=%0b",
                   $time, exp_c.x, exp_c.y, exp_c.z, exp_c.nx, exp_c.ny, exp_c.nz,
                   exp_c.status, exp_c.last);
          $display("%0t:          actual   x=%h y=%h z=%h n=%h,%h,%h st=%0d last=%0b",
                   $time, got.x, got.y, got.z, got.nx, got.ny, got.nz,
                   got.status, got.last);
          error_count <= error_count + 1;
        end
      end
      out_took <= 1'b1;
    end
  end

  // After each transfer the receiver draws a random hold and stalls until it runs out.
  int hold_left = 0;
  always @(negedge clk) begin
    int hold_now;
    hold_now = hold_left;
    if (out_took) hold_now = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    if (hold_now > 0) begin
      out_stall <= 1'b1;
      hold_now = hold_now - 1;
    end else begin
      out_stall <= 1'b0;
    end
    hold_left <= hold_now;
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int slot[3];
    for (int i = 0; i < DEPTH; i++) vtx_written[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: extremes, out-of-range writes, bad and unwritten corners, degenerate.
    queue_item(face(0, 1, 2));
    queue_item(vertex_write(0, 32'h7fffffff, 32'h80000000, 32'h0));
    queue_item(vertex_write(1, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
    queue_item(vertex_write(2, 32'h0, 32'h0, 32'h80000000));
    queue_item(vertex_write(DEPTH - 1, 32'hffffffff, 32'h1, 32'h10000));
    queue_item(vertex_write(DEPTH, 32'h5, 32'h5, 32'h5));
    queue_item(vertex_write(16'hffff, 32'h7, 32'h7, 32'h7));
    queue_item(face(0, 1, 2));
    queue_item(face(2, 1, 0));
    queue_item(face(0, 1, DEPTH - 1));
    queue_item(face(0, 0, 0));
    queue_item(face(0, 1, 1));
    queue_item(face(DEPTH, 0, 1));
    queue_item(face(0, 16'hffff, 1));
    queue_item(face(0, 1, 3));
    queue_item(vertex_write(3, 32'h10000, 32'h0, 32'h0));
    queue_item(vertex_write(4, 32'h0, 32'h10000, 32'h0));
    queue_item(vertex_write(5, 32'h20000, 32'h0, 32'h0));
    queue_item(face(2, 3, 4));
    queue_item(face(2, 3, 5));
    queue_item(vertex_write(6, 32'h0, 32'h0, 32'h1));
    queue_item(face(2, 3, 6));
    queue_item(face(DEPTH - 1, 0, 6));

    // Random part: mostly writes of a few slots followed by a face over them.
    for (int n = 0; n < 60; n++) begin
      for (int k = 0; k < 3; k++) begin
        slot[k] = $urandom_range(0, 3) == 0 ? $urandom_range(0, DEPTH - 1)
                                            : $urandom_range(0, 31);
        if ($urandom_range(0, 4) != 0)
          queue_item(vertex_write(slot[k], rand_coord(), rand_coord(), rand_coord()));
      end
      case ($urandom_range(0, 9))
        0: queue_item(face($urandom, $urandom, $urandom));
        1: queue_item(face(slot[0], slot[0], slot[1]));
        2: queue_item(vertex_write($urandom, $urandom, $urandom, $urandom));
        default: queue_item(face(slot[0], slot[1], slot[2]));
      endcase
    end

    wait (pending_items.size() == 0);
    wait (expected_corners.size() == 0);
    repeat (200) @(posedge clk);
    $display("Covered %0d face transfers and %0d result transfers with random gaps.",
             faces_sent, corners_seen);
    if (error_count == 0 && expected_corners.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
